// File: rtl/core/half_duplex_timer_uart_channel_assert.svh
// ----------------------------------------------------------------------------
// half_duplex_timer_uart_channel assertion macros
// shared assertion forms for the uart channel rtl
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_TIMER_UART_CHANNEL_ASSERT_SVH
`define HALF_DUPLEX_TIMER_UART_CHANNEL_ASSERT_SVH

// same-cycle implication
`define HDTU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hdtu_pkg.sv
// ----------------------------------------------------------------------------
// hdtu_pkg
// commands, modes, register indexes and shared types of the uart channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdtu_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_ARM  = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_RECV = 2'd2;
  localparam logic [1:0] MODE_SEND = 2'd3;

  localparam logic [1:0] REG_BIT_PERIOD  = 2'd0;
  localparam logic [1:0] REG_HALF_PERIOD = 2'd1;
  localparam logic [1:0] REG_AUTO_REARM  = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int TIMER_W    = 17;
  localparam int COUNT_W    = 4;

  localparam logic [15:0] BIT_PERIOD_RST  = 16'd104;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd52;

  typedef struct packed {
    logic [15:0] bit_period;
    logic [15:0] half_period;
    logic        auto_rearm;
  } cfg_t;

  typedef struct packed {
    logic [1:0] channel_mode;
    logic       tx_done;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_line;
  } result_t;

endpackage

// File: rtl/core/hdtu_core.sv
// ----------------------------------------------------------------------------
// hdtu_core
// channel state registers and the state update applied for each request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "half_duplex_timer_uart_channel_assert.svh"

module hdtu_core #(
  parameter int DATA_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  hdtu_pkg::cfg_t  cfg,
  input  logic            step_en,
  input  logic [1:0]      cmd,
  input  logic [7:0]      tx_byte,
  input  logic            rx_level,
  output hdtu_pkg::result_t result
);

  localparam int FRAME_W = DATA_BITS + 2;
  localparam logic [hdtu_pkg::COUNT_W-1:0] DATA_CNT  = hdtu_pkg::COUNT_W'(DATA_BITS);
  localparam logic [hdtu_pkg::COUNT_W-1:0] FRAME_CNT = hdtu_pkg::COUNT_W'(DATA_BITS + 2);

  typedef enum logic [1:0] {
    M_IDLE = hdtu_pkg::MODE_IDLE,
    M_WAIT = hdtu_pkg::MODE_WAIT,
    M_RECV = hdtu_pkg::MODE_RECV,
    M_SEND = hdtu_pkg::MODE_SEND
  } mode_t;

  mode_t                             mode, mode_next;
  logic [FRAME_W-1:0]                shifter, shifter_next;
  logic [hdtu_pkg::COUNT_W-1:0]      bits_left, bits_left_next;
  logic [hdtu_pkg::TIMER_W-1:0]      tick_timer, tick_timer_next;
  logic                              line_out, line_out_next;
  logic                              last_rx_level;
  logic [7:0]                        received, received_next;
  logic                              send_finished, send_finished_next;
  logic                              rx_valid_next;

  logic                              timer_evt;
  logic [hdtu_pkg::TIMER_W-1:0]      timer_step;
  logic [FRAME_W-1:0]                rx_shifted;
  logic [hdtu_pkg::COUNT_W-1:0]      bits_dec;

  always_comb begin
    timer_evt  = (tick_timer <= hdtu_pkg::TIMER_W'(1));
    timer_step = timer_evt ? hdtu_pkg::TIMER_W'(cfg.bit_period)
                           : tick_timer - hdtu_pkg::TIMER_W'(1);
    rx_shifted = (shifter >> 1) | (FRAME_W'(rx_level) << (DATA_BITS - 1));
    bits_dec   = (bits_left != '0) ? bits_left - hdtu_pkg::COUNT_W'(1) : '0;
  end

  always_comb begin
    mode_next          = mode;
    shifter_next       = shifter;
    bits_left_next     = bits_left;
    tick_timer_next    = tick_timer;
    line_out_next      = line_out;
    received_next      = received;
    send_finished_next = send_finished;
    rx_valid_next      = 1'b0;
    unique case (cmd)
      hdtu_pkg::CMD_SEND: begin
        shifter_next       = {1'b1, DATA_BITS'(tx_byte), 1'b0};
        bits_left_next     = FRAME_CNT;
        tick_timer_next    = hdtu_pkg::TIMER_W'(cfg.bit_period);
        line_out_next      = 1'b1;
        send_finished_next = 1'b0;
        mode_next          = M_SEND;
      end
      hdtu_pkg::CMD_ARM: begin
        line_out_next  = 1'b1;
        bits_left_next = DATA_CNT;
        shifter_next   = '0;
        mode_next      = M_WAIT;
      end
      hdtu_pkg::CMD_TICK: begin
        unique case (mode)
          M_WAIT: begin
            if (last_rx_level && !rx_level) begin
              tick_timer_next = hdtu_pkg::TIMER_W'(cfg.bit_period)
                              + hdtu_pkg::TIMER_W'(cfg.half_period);
              shifter_next    = '0;
              bits_left_next  = DATA_CNT;
              mode_next       = M_RECV;
            end
          end
          M_RECV: begin
            tick_timer_next = timer_step;
            if (timer_evt) begin
              shifter_next   = rx_shifted;
              bits_left_next = bits_dec;
              if (bits_dec == '0) begin
                received_next  = 8'(rx_shifted);
                rx_valid_next  = 1'b1;
                bits_left_next = DATA_CNT;
                shifter_next   = '0;
                mode_next      = cfg.auto_rearm ? M_WAIT : M_IDLE;
              end
            end
          end
          M_SEND: begin
            tick_timer_next = timer_step;
            if (timer_evt) begin
              if (bits_left == '0) begin
                send_finished_next = 1'b1;
                mode_next          = M_IDLE;
              end else begin
                line_out_next  = shifter[0];
                shifter_next   = shifter >> 1;
                bits_left_next = bits_dec;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      shifter       <= '0;
      bits_left     <= '0;
      tick_timer    <= '0;
      line_out      <= 1'b1;
      last_rx_level <= 1'b1;
      received      <= '0;
      send_finished <= 1'b0;
    end else if (step_en) begin
      mode          <= mode_next;
      shifter       <= shifter_next;
      bits_left     <= bits_left_next;
      tick_timer    <= tick_timer_next;
      line_out      <= line_out_next;
      last_rx_level <= rx_level;
      received      <= received_next;
      send_finished <= send_finished_next;
    end
  end

  assign result.channel_mode = mode_next;
  assign result.tx_done      = send_finished_next;
  assign result.rx_valid     = rx_valid_next;
  assign result.rx_byte      = received_next;
  assign result.tx_line      = line_out_next;

  `HDTU_ASSERT_IMPLY(a_line_idle_mark, clk, rst, mode != M_SEND, line_out,
    "line low outside transmit")
  `HDTU_ASSERT_IMPLY(a_recv_count, clk, rst, mode == M_RECV,
    (bits_left != '0) && (bits_left <= DATA_CNT), "receive bit count out of range")
  `HDTU_ASSERT_NEXT(a_send_start, clk, rst, step_en && (cmd == hdtu_pkg::CMD_SEND),
    (mode == M_SEND) && !send_finished && (bits_left == FRAME_CNT),
    "send request did not start a frame")

endmodule

// File: rtl/core/half_duplex_timer_uart_channel.sv
// ----------------------------------------------------------------------------
// half_duplex_timer_uart_channel
// one half-duplex 8n1 uart channel stepped by baud tick requests
// ----------------------------------------------------------------------------
//  channel | bus                 | contents
//  s_      | tvalid/tready/tdata | tdata: tx_byte[7:0], rx_level[8]; tuser: cmd
//  m_      | tvalid/tready/tdata | tdata: tx_line, rx_byte, rx_valid, tx_done, mode
//  cfg_    | we/index/data       | 0 bit_period, 1 half_period, 2 auto_rearm
//
//  one request per cycle sustained with m_tready high; m_tvalid rises after the
//  input register, then the state update and result register in the same cycle
//  a held result does not block the next request until the input register fills
//  rst is synchronous: idle mode, line at mark, registers at 104 / 52 / 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "half_duplex_timer_uart_channel_assert.svh"

module half_duplex_timer_uart_channel #(
  parameter int DATA_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // tx_byte[7:0], rx_level[8], zero fill
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // tx_line[0], rx_byte[8:1], rx_valid[9],
                                 // tx_done[10], channel_mode[12:11], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  hdtu_pkg::cfg_t    cfg;
  logic              in_valid;
  logic [1:0]        in_cmd;
  logic [7:0]        in_byte;
  logic              in_rx;
  logic              fire;
  hdtu_pkg::result_t step_res;
  logic              out_valid;
  hdtu_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period  <= hdtu_pkg::BIT_PERIOD_RST;
      cfg.half_period <= hdtu_pkg::HALF_PERIOD_RST;
      cfg.auto_rearm  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdtu_pkg::REG_BIT_PERIOD:  cfg.bit_period  <= cfg_data;
        hdtu_pkg::REG_HALF_PERIOD: cfg.half_period <= cfg_data;
        hdtu_pkg::REG_AUTO_REARM:  cfg.auto_rearm  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= s_tuser;
      in_byte <= s_tdata[7:0];
      in_rx   <= s_tdata[8];
    end
    if (fire) begin
      out_res <= step_res;
    end
  end

  hdtu_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step_en  (fire),
    .cmd      (in_cmd),
    .tx_byte  (in_byte),
    .rx_level (in_rx),
    .result   (step_res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res};

  `HDTU_ASSERT_IMPLY(a_rx_valid_mode, clk, rst, out_valid && out_res.rx_valid,
    (out_res.channel_mode == hdtu_pkg::MODE_WAIT) ||
    (out_res.channel_mode == hdtu_pkg::MODE_IDLE), "byte completed outside receive end")
  `HDTU_ASSERT_NEXT(a_held_request, clk, rst, in_valid && !fire,
    in_valid && $stable(in_cmd), "pending request lost")
  `HDTU_ASSERT_NEXT(a_held_result, clk, rst, out_valid && !m_tready,
    out_valid && $stable(out_res), "held result changed")

endmodule
